// File: hw/rtl/hps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Horner polynomial sampler package
// Widths, register indexes, saturation limits and the structs shared by the
// sampler modules.
// ----------------------------------------------------------------------------
package hps_pkg;

  localparam int X_W               = 32;
  localparam int Y_W               = 48;
  localparam int COEF_W            = 32;
  localparam int IDX_W             = 12;
  localparam int ORDER_W           = 3;
  localparam int FRAC_W            = 16;
  localparam int COEF_NUM          = 5;
  localparam int DEFAULT_MAX_ORDER = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 80;

  localparam logic [CFG_IDX_W-1:0] REG_X_START    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_STEP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POLY_ORDER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_ZERO  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_ONE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_TWO   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_THREE = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_FOUR  = 3'd7;

  localparam logic signed [X_W-1:0] X_STEP_RESET = 32'sh0001_0000;

  localparam logic signed [X_W-1:0] X_MAX = {1'b0, {(X_W-1){1'b1}}};
  localparam logic signed [X_W-1:0] X_MIN = {1'b1, {(X_W-1){1'b0}}};
  localparam logic signed [Y_W-1:0] Y_MAX = {1'b0, {(Y_W-1){1'b1}}};
  localparam logic signed [Y_W-1:0] Y_MIN = {1'b1, {(Y_W-1){1'b0}}};

  typedef struct packed {
    logic signed [X_W-1:0]           x_start;
    logic signed [X_W-1:0]           x_step;
    logic [COEF_NUM-1:0][COEF_W-1:0] coef;
  } cfg_t;

  typedef struct packed {
    logic signed [X_W-1:0] x;
    logic signed [Y_W-1:0] y;
    logic                  ovf;
    logic                  last;
  } sample_t;

endpackage

// File: hw/rtl/hps_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the sweep and coefficient registers and presents the coefficients
// with every term above the effective order forced to zero.
// ----------------------------------------------------------------------------
module hps_cfg_regs import hps_pkg::*; #(
  parameter int MAX_ORDER = DEFAULT_MAX_ORDER
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  logic signed [X_W-1:0]           x_start;
  logic signed [X_W-1:0]           x_step;
  logic [ORDER_W-1:0]              poly_order;
  logic [ORDER_W-1:0]              order_eff;
  logic [COEF_NUM-1:0][COEF_W-1:0] coef;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_start    <= '0;
      x_step     <= X_STEP_RESET;
      poly_order <= '0;
      coef       <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_X_START:    x_start    <= cfg_data[X_W-1:0];
        REG_X_STEP:     x_step     <= cfg_data[X_W-1:0];
        REG_POLY_ORDER: poly_order <= cfg_data[ORDER_W-1:0];
        REG_COEF_ZERO:  coef[0]    <= cfg_data[COEF_W-1:0];
        REG_COEF_ONE:   coef[1]    <= cfg_data[COEF_W-1:0];
        REG_COEF_TWO:   coef[2]    <= cfg_data[COEF_W-1:0];
        REG_COEF_THREE: coef[3]    <= cfg_data[COEF_W-1:0];
        REG_COEF_FOUR:  coef[4]    <= cfg_data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // Leading zero terms make Horner's rule start at the configured order.
  always_comb begin
    order_eff   = (poly_order > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : poly_order;
    cfg.x_start = x_start;
    cfg.x_step  = x_step;
    for (int j = 0; j < COEF_NUM; j++) begin
      cfg.coef[j] = (ORDER_W'(j) <= order_eff) ? coef[j] : '0;
    end
  end

endmodule

// File: hw/rtl/hps_abscissa.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Abscissa stages
// Two pipeline stages forming x = x_start + x_step * index with saturation,
// and seeding the accumulator with the top coefficient.
// ----------------------------------------------------------------------------
module hps_abscissa import hps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [IDX_W-1:0]      sample_index,
  input  logic                  last_in,
  input  logic signed [X_W-1:0] x_start,
  input  logic signed [X_W-1:0] x_step,
  input  logic [COEF_W-1:0]     coef_top,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sample_t               out
);

  localparam int PROD_W = X_W + IDX_W + 1;
  localparam int SUM_W  = PROD_W + 1;

  logic                    a_valid;
  logic                    a_en;
  logic                    b_en;
  logic signed [PROD_W-1:0] prod;
  logic                    a_last;
  logic signed [SUM_W-1:0] x_sum;
  logic                    x_hi;
  logic                    x_lo;
  logic signed [X_W-1:0]   x_sat;

  assign b_en     = !out_valid || out_ready;
  assign a_en     = !a_valid || b_en;
  assign in_ready = a_en;

  always_comb begin
    x_sum = SUM_W'(x_start) + SUM_W'(prod);
    x_hi  = !x_sum[SUM_W-1] && (x_sum[SUM_W-2:X_W-1] != '0);
    x_lo  = x_sum[SUM_W-1] && (x_sum[SUM_W-2:X_W-1] != '1);
    if (x_hi) begin
      x_sat = X_MAX;
    end else if (x_lo) begin
      x_sat = X_MIN;
    end else begin
      x_sat = x_sum[X_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a_en) begin
        a_valid <= in_valid;
      end
      if (b_en) begin
        out_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_en && in_valid) begin
      prod   <= x_step * $signed({1'b0, sample_index});
      a_last <= last_in;
    end
    if (b_en && a_valid) begin
      out.x    <= x_sat;
      out.y    <= {{(Y_W-COEF_W){coef_top[COEF_W-1]}}, coef_top};
      out.ovf  <= x_hi || x_lo;
      out.last <= a_last;
    end
  end

endmodule

// File: hw/rtl/hps_horner_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Horner step
// One step y = floor(y * x / 2^16) + c in two stages: split partial products,
// then sum, coefficient add, rounding toward minus infinity and saturation.
// ----------------------------------------------------------------------------
module hps_horner_step import hps_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sample_t           in,
  input  logic [COEF_W-1:0] coef,
  output logic              out_valid,
  input  logic              out_ready,
  output sample_t           out
);

  localparam int LO_W  = 32;
  localparam int HI_W  = Y_W - LO_W;
  localparam int PLO_W = LO_W + 1 + X_W;
  localparam int PHI_W = HI_W + X_W;
  localparam int SUM_W = Y_W + X_W + 1;
  localparam int SHR_W = SUM_W - FRAC_W;

  logic                     a_valid;
  logic                     a_en;
  logic                     b_en;
  logic signed [PLO_W-1:0]  p_lo;
  logic signed [PHI_W-1:0]  p_hi;
  logic signed [X_W-1:0]    a_x;
  logic                     a_ovf;
  logic                     a_last;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SHR_W-1:0]  t;
  logic                     t_hi;
  logic                     t_lo;
  logic signed [Y_W-1:0]    y_sat;

  assign b_en     = !out_valid || out_ready;
  assign a_en     = !a_valid || b_en;
  assign in_ready = a_en;

  always_comb begin
    sum = (SUM_W'(p_hi) <<< LO_W) + SUM_W'(p_lo) + (SUM_W'($signed(coef)) <<< FRAC_W);
    t    = sum[SUM_W-1:FRAC_W];
    t_hi = !t[SHR_W-1] && (t[SHR_W-2:Y_W-1] != '0);
    t_lo = t[SHR_W-1] && (t[SHR_W-2:Y_W-1] != '1);
    if (t_hi) begin
      y_sat = Y_MAX;
    end else if (t_lo) begin
      y_sat = Y_MIN;
    end else begin
      y_sat = t[Y_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a_en) begin
        a_valid <= in_valid;
      end
      if (b_en) begin
        out_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_en && in_valid) begin
      p_lo   <= $signed({1'b0, in.y[LO_W-1:0]}) * in.x;
      p_hi   <= $signed(in.y[Y_W-1:LO_W]) * in.x;
      a_x    <= in.x;
      a_ovf  <= in.ovf;
      a_last <= in.last;
    end
    if (b_en && a_valid) begin
      out.x    <= a_x;
      out.y    <= y_sat;
      out.ovf  <= a_ovf || t_hi || t_lo;
      out.last <= a_last;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out))
    else $error("Stalled Horner result changed.");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    a_valid && b_en |=> out_valid)
    else $error("Product stage lost a transaction.");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    a_valid && b_en && a_ovf |=> out.ovf)
    else $error("Overflow flag dropped in a Horner step.");

  a_ovf_cause: assert property (@(posedge clk) disable iff (rst)
    a_valid && b_en && !a_ovf |=> !out.ovf || out.y == Y_MAX || out.y == Y_MIN)
    else $error("Overflow raised without saturation.");

endmodule

// File: hw/rtl/horner_polynomial_sampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Horner polynomial sampler
// Evaluates a configured polynomial at x = x_start + x_step * index by
// Horner's rule in saturating fixed point, one sample per clock when not stalled.
// ----------------------------------------------------------------------------
// Pipeline: two stages for the abscissa and two for each Horner step
// (partial products, then sum and clamp).
// Throughput: one transaction per clock; every stage has its own valid bit
// and stalls only while the stage after it is full and stalled.
// Reset: synchronous rst empties the pipeline and restores register defaults.
// ----------------------------------------------------------------------------
module horner_polynomial_sampler import hps_pkg::*; #(
  parameter int MAX_ORDER = DEFAULT_MAX_ORDER
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,  // sample_index
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,  // x_value, y_value
  output logic                  m_tuser,  // overflow
  output logic                  m_tlast
);

  cfg_t    cfg;
  sample_t chain       [MAX_ORDER:0];
  logic    chain_valid [MAX_ORDER:0];
  logic    chain_ready [MAX_ORDER:0];

  hps_cfg_regs #(
    .MAX_ORDER (MAX_ORDER)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hps_abscissa u_abscissa (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .sample_index (s_tdata[IDX_W-1:0]),
    .last_in      (s_tlast),
    .x_start      (cfg.x_start),
    .x_step       (cfg.x_step),
    .coef_top     (cfg.coef[MAX_ORDER]),
    .out_valid    (chain_valid[0]),
    .out_ready    (chain_ready[0]),
    .out          (chain[0])
  );

  for (genvar k = 0; k < MAX_ORDER; k++) begin : g_step
    hps_horner_step u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[k]),
      .in_ready  (chain_ready[k]),
      .in        (chain[k]),
      .coef      (cfg.coef[MAX_ORDER-1-k]),
      .out_valid (chain_valid[k+1]),
      .out_ready (chain_ready[k+1]),
      .out       (chain[k+1])
    );
  end

  assign chain_ready[MAX_ORDER] = m_tready;
  assign m_tvalid = chain_valid[MAX_ORDER];
  assign m_tdata  = {chain[MAX_ORDER].y, chain[MAX_ORDER].x};
  assign m_tuser  = chain[MAX_ORDER].ovf;
  assign m_tlast  = chain[MAX_ORDER].last;

endmodule
